// ===== design/gec_pkg.sv =====
// ----------------------------------------------------------------------------
// gec_pkg: shared types and constants for graph edge connectivity
// Sizes of the graph stores, payload structs, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gec_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned MaxDegree   = 16;
  localparam int unsigned VIdxW       = $clog2(MaxVertices);
  localparam int unsigned CellW       = 2 * VIdxW;
  localparam int unsigned Cells       = MaxVertices * MaxVertices;
  localparam int unsigned VNumW       = 6;
  localparam int unsigned CapW        = 5;
  localparam int unsigned FlowW       = 6;
  localparam int unsigned CntW        = 5;
  localparam logic [VNumW-1:0] VcReset = VNumW'(32);

  typedef struct packed {
    logic [VNumW-1:0] vertex;
    logic [VNumW-1:0] neighbour;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [CntW-1:0] connectivity;
    logic            overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LFIN,
    ST_DEG_RD,
    ST_DEG_ACC,
    ST_TGT,
    ST_FCLR,
    ST_AUG,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr_all;
    logic clr_flow;
    logic load;
    logic deg_init;
    logic deg_acc;
    logic flow_init;
    logic tgt_next;
    logic fail_set;
    logic aug_init;
    logic skip;
    logic pop;
    logic eval;
    logic done_set;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic deg_last;
    logic t_over;
    logic t_is_src;
    logic count_ge_best;
    logic v_over;
    logic v_onpath;
    logic sp_zero;
    logic ev_ok;
    logic ev_hit;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/gec_datapath.sv =====
// ----------------------------------------------------------------------------
// gec_datapath: graph stores, search registers and result register
// Holds capacity and flow memories, degree counters, the DFS stack and
// visited marks, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module gec_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gec_pkg::cmd_t            cmd_i,
  output gec_pkg::sts_t                 sts_o,
  input  wire gec_pkg::in_item_t        in_data_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [gec_pkg::VNumW-1:0] cfg_data_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output gec_pkg::out_item_t            out_data_o
);

  localparam int unsigned VW = gec_pkg::VIdxW;
  localparam int unsigned NW = gec_pkg::VNumW;
  localparam int unsigned AW = gec_pkg::CellW;
  localparam int unsigned CW = gec_pkg::CapW;
  localparam int unsigned FW = gec_pkg::FlowW;
  localparam int unsigned KW = gec_pkg::CntW;
  localparam int unsigned NV = gec_pkg::MaxVertices;

  // memories
  logic [CW-1:0] cap_mem  [gec_pkg::Cells];
  logic [FW-1:0] flow_mem [gec_pkg::Cells];
  logic [CW-1:0] cap_q;
  logic [FW-1:0] fa_q, fb_q;

  // control and search registers
  logic [NW-1:0] vc_q;
  logic [AW-1:0] sweep_q;
  logic [CW-1:0] deg_q [NV];
  logic          ovf_q;
  logic          pend_q;
  logic [AW-1:0] pend_addr_q;
  logic          lw_v_q;
  logic [AW-1:0] lw_addr_q;
  logic [CW-1:0] lw_data_q;
  logic [VW-1:0] u_q;
  logic [NW-1:0] v_q;
  logic [NW-1:0] t_q;
  logic [VW-1:0] src_q;
  logic [KW-1:0] dsum_q, least_q, best_q, count_q;
  logic [VW-1:0] sp_q;
  logic [NV-1:0] on_path_q;
  logic [VW-1:0] stk_u [NV];
  logic [VW-1:0] stk_v [NV];
  logic [FW-1:0] stk_f [NV];
  logic          out_valid_q;
  gec_pkg::out_item_t out_q;

  // effective vertex count
  logic [NW-1:0] n_eff;
  logic [VW-1:0] nm1;
  always_comb begin
    if (vc_q == '0) begin
      n_eff = NW'(1);
    end else if (vc_q > NW'(NV)) begin
      n_eff = NW'(NV);
    end else begin
      n_eff = vc_q;
    end
  end
  assign nm1 = VW'(n_eff - NW'(1));

  // decode the incoming entry
  logic [NW-1:0] vm1, wm1;
  logic          in_rng, deg_full;
  logic [AW-1:0] ld_addr;
  assign vm1      = in_data_i.vertex - NW'(1);
  assign wm1      = in_data_i.neighbour - NW'(1);
  assign in_rng   = (vm1 < NW'(NV)) && (wm1 < NW'(NV));
  assign ld_addr  = {vm1[VW-1:0], wm1[VW-1:0]};
  assign deg_full = (deg_q[vm1[VW-1:0]] == CW'(gec_pkg::MaxDegree));

  // capacity write: pending increment wins over clearing
  logic [CW-1:0] cap_base;
  logic          cap_we;
  logic [AW-1:0] cap_waddr, cap_raddr;
  logic [CW-1:0] cap_wdata;
  assign cap_base  = (lw_v_q && (lw_addr_q == pend_addr_q)) ? lw_data_q : cap_q;
  assign cap_raddr = cmd_i.load ? ld_addr : {u_q, v_q[VW-1:0]};
  always_comb begin
    cap_we    = 1'b0;
    cap_waddr = sweep_q;
    cap_wdata = '0;
    if (pend_q) begin
      cap_we    = 1'b1;
      cap_waddr = pend_addr_q;
      cap_wdata = cap_base + CW'(1);
    end else if (cmd_i.clr_all) begin
      cap_we = 1'b1;
    end
  end

  // residual test on the registered reads
  logic ev_ok, ev_hit;
  logic [VW-1:0] top;
  assign ev_ok  = ({1'b0, fa_q}) < (({1'b0, fb_q}) + (FW+1)'(cap_q));
  assign ev_hit = (v_q[VW-1:0] == t_q[VW-1:0]);
  assign top    = sp_q - VW'(1);

  // flow write
  logic          flow_we;
  logic [AW-1:0] flow_waddr;
  logic [FW-1:0] flow_wdata;
  always_comb begin
    flow_we    = 1'b0;
    flow_waddr = sweep_q;
    flow_wdata = '0;
    if (cmd_i.clr_all || cmd_i.clr_flow) begin
      flow_we = 1'b1;
    end else if (cmd_i.eval && ev_ok) begin
      flow_we    = 1'b1;
      flow_waddr = {u_q, v_q[VW-1:0]};
      flow_wdata = fa_q + FW'(1);
    end else if (cmd_i.pop) begin
      flow_we    = 1'b1;
      flow_waddr = {stk_u[top], stk_v[top]};
      flow_wdata = stk_f[top];
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      cap_mem[cap_waddr] <= cap_wdata;
    end
    cap_q <= cap_mem[cap_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (flow_we) begin
      flow_mem[flow_waddr] <= flow_wdata;
    end
    fa_q <= flow_mem[{u_q, v_q[VW-1:0]}];
    fb_q <= flow_mem[{v_q[VW-1:0], u_q}];
  end

  // push onto the search stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && ev_ok) begin
      stk_u[sp_q] <= u_q;
      stk_v[sp_q] <= v_q[VW-1:0];
      stk_f[sp_q] <= fa_q;
    end
  end

  // degree row sum and running minimum
  logic [KW-1:0] dnew, least_sel;
  logic [VW-1:0] src_sel;
  logic          row_end, take;
  assign dnew      = dsum_q + KW'(cap_q);
  assign row_end   = (v_q[VW-1:0] == nm1);
  assign take      = (u_q == '0) || (dnew < least_q);
  assign least_sel = take ? dnew : least_q;
  assign src_sel   = take ? u_q : src_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= gec_pkg::VcReset;
      sweep_q     <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      lw_v_q      <= 1'b0;
      lw_addr_q   <= '0;
      lw_data_q   <= '0;
      u_q         <= '0;
      v_q         <= '0;
      t_q         <= '0;
      src_q       <= '0;
      dsum_q      <= '0;
      least_q     <= '0;
      best_q      <= '0;
      count_q     <= '0;
      sp_q        <= '0;
      on_path_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < NV; i++) begin
        deg_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_data_i;
      end
      if (cmd_i.clr_all || cmd_i.clr_flow) begin
        sweep_q <= sweep_q + AW'(1);
      end

      // track the last capacity write for forwarding
      lw_v_q    <= pend_q;
      lw_addr_q <= pend_addr_q;
      lw_data_q <= cap_wdata;
      pend_q    <= cmd_i.load && in_rng && !deg_full;
      if (cmd_i.load) begin
        pend_addr_q <= ld_addr;
      end

      // count entries per vertex
      if (cmd_i.done_set) begin
        ovf_q <= 1'b0;
        for (int i = 0; i < NV; i++) begin
          deg_q[i] <= '0;
        end
      end else if (cmd_i.load && in_rng) begin
        if (deg_full) begin
          ovf_q <= 1'b1;
        end else begin
          deg_q[vm1[VW-1:0]] <= deg_q[vm1[VW-1:0]] + CW'(1);
        end
      end

      if (cmd_i.deg_init) begin
        u_q    <= '0;
        v_q    <= '0;
        dsum_q <= '0;
      end
      if (cmd_i.deg_acc) begin
        if (row_end) begin
          dsum_q  <= '0;
          v_q     <= '0;
          u_q     <= u_q + VW'(1);
          least_q <= least_sel;
          src_q   <= src_sel;
          if (u_q == nm1) begin
            best_q <= least_sel;
            t_q    <= '0;
          end
        end else begin
          dsum_q <= dnew;
          v_q    <= v_q + NW'(1);
        end
      end

      if (cmd_i.flow_init) begin
        count_q <= '0;
      end
      if (cmd_i.tgt_next) begin
        t_q <= t_q + NW'(1);
      end
      if (cmd_i.fail_set) begin
        best_q <= count_q;
        t_q    <= t_q + NW'(1);
      end

      // depth-first search steps
      if (cmd_i.aug_init) begin
        on_path_q <= NV'(1) << src_q;
        u_q       <= src_q;
        v_q       <= '0;
        sp_q      <= '0;
      end
      if (cmd_i.skip) begin
        v_q <= v_q + NW'(1);
      end
      if (cmd_i.pop) begin
        sp_q <= top;
        u_q  <= stk_u[top];
        v_q  <= NW'(stk_v[top]) + NW'(1);
      end
      if (cmd_i.eval) begin
        if (ev_ok) begin
          sp_q <= sp_q + VW'(1);
          if (ev_hit) begin
            count_q <= count_q + KW'(1);
          end else begin
            on_path_q[v_q[VW-1:0]] <= 1'b1;
            u_q <= v_q[VW-1:0];
            v_q <= '0;
          end
        end else begin
          v_q <= v_q + NW'(1);
        end
      end

      // result register
      if (cmd_i.done_set) begin
        out_valid_q        <= 1'b1;
        out_q.connectivity <= best_q;
        out_q.overflow     <= ovf_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts_o.sweep_last    = &sweep_q;
    sts_o.deg_last      = row_end && (u_q == nm1);
    sts_o.t_over        = (t_q >= n_eff);
    sts_o.t_is_src      = (t_q[VW-1:0] == src_q);
    sts_o.count_ge_best = (count_q >= best_q);
    sts_o.v_over        = (v_q >= n_eff);
    sts_o.v_onpath      = on_path_q[v_q[VW-1:0]];
    sts_o.sp_zero       = (sp_q == '0);
    sts_o.ev_ok         = ev_ok;
    sts_o.ev_hit        = ev_hit;
    sts_o.out_busy      = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/gec_ctrl.sv =====
// ----------------------------------------------------------------------------
// gec_ctrl: sequencing state machine
// Steps through clearing, loading, degree scan, per-target flow clearing
// and the depth-first augmenting search, one command set per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gec_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  input  wire gec_pkg::sts_t sts_i,
  output gec_pkg::cmd_t      cmd_o
);

  gec_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gec_pkg::ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gec_pkg::ST_CLR: begin
        cmd_o.clr_all = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = gec_pkg::ST_IDLE;
        end
      end
      gec_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = gec_pkg::ST_LFIN;
          end
        end
      end
      gec_pkg::ST_LFIN: begin
        cmd_o.deg_init = 1'b1;
        state_d        = gec_pkg::ST_DEG_RD;
      end
      gec_pkg::ST_DEG_RD: begin
        state_d = gec_pkg::ST_DEG_ACC;
      end
      gec_pkg::ST_DEG_ACC: begin
        cmd_o.deg_acc = 1'b1;
        state_d = sts_i.deg_last ? gec_pkg::ST_TGT : gec_pkg::ST_DEG_RD;
      end
      gec_pkg::ST_TGT: begin
        if (sts_i.t_over) begin
          state_d = gec_pkg::ST_DONE;
        end else if (sts_i.t_is_src) begin
          cmd_o.tgt_next = 1'b1;
        end else begin
          cmd_o.flow_init = 1'b1;
          state_d         = gec_pkg::ST_FCLR;
        end
      end
      gec_pkg::ST_FCLR: begin
        cmd_o.clr_flow = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = gec_pkg::ST_AUG;
        end
      end
      gec_pkg::ST_AUG: begin
        if (sts_i.count_ge_best) begin
          cmd_o.tgt_next = 1'b1;
          state_d        = gec_pkg::ST_TGT;
        end else begin
          cmd_o.aug_init = 1'b1;
          state_d        = gec_pkg::ST_SCAN;
        end
      end
      gec_pkg::ST_SCAN: begin
        if (sts_i.v_over) begin
          if (sts_i.sp_zero) begin
            cmd_o.fail_set = 1'b1;
            state_d        = gec_pkg::ST_TGT;
          end else begin
            cmd_o.pop = 1'b1;
          end
        end else if (sts_i.v_onpath) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = gec_pkg::ST_EVAL;
        end
      end
      gec_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = (sts_i.ev_ok && sts_i.ev_hit) ? gec_pkg::ST_AUG : gec_pkg::ST_SCAN;
      end
      gec_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.done_set = 1'b1;
          state_d        = gec_pkg::ST_CLR;
        end
      end
      default: begin
        state_d = gec_pkg::ST_CLR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/graph_edge_connectivity.sv =====
// ----------------------------------------------------------------------------
// graph_edge_connectivity: edge connectivity of a loaded multigraph
// Loads adjacency entries, then finds the minimum edge cut by repeated
// augmenting-path max flow from the vertex of least degree.
// ----------------------------------------------------------------------------
//  channel | direction | payload      | transaction
//  in      | input     | in_item_t    | one adjacency entry
//  out     | output    | out_item_t   | one connectivity result
//  cfg     | input     | vertex count | one register write, always ready
//
//  Entries load one per cycle; the capacity read-modify-write is pipelined.
//  After the last entry: a setup step, a degree scan, then per target a flow
//  clear and a depth-first search that evaluates, skips or backtracks over arcs
//  and starts again for each new augmenting path.
//  A capacity clear follows reset and every result; entries wait.
//  A result waits in the output register; a new one is held back until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_edge_connectivity (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire gec_pkg::in_item_t         in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output gec_pkg::out_item_t             out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [gec_pkg::VNumW-1:0] cfg_data_i
);

  gec_pkg::cmd_t cmd;
  gec_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  gec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gec_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== design/gec_checker.sv =====
// ----------------------------------------------------------------------------
// gec_checker: port-level checks for graph_edge_connectivity
// Watches the channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module gec_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire gec_pkg::in_item_t         in_data_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire gec_pkg::out_item_t        out_data_o,
  input wire logic                      cfg_ready_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // configuration is never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  // cut size never exceeds the degree limit
  a_conn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.connectivity <= 5'(gec_pkg::MaxDegree))
    else $error("connectivity out of range");

  // stop taking entries after the last one
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last |=> !in_ready_o)
    else $error("entry taken after last");

  // a new result appears only while loading is closed
  a_result_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result while loading");

endmodule

bind graph_edge_connectivity gec_checker u_gec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
